// ===== hdl/hbm_pkg.sv =====
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types, codes and constants of the heartbeat monitor.
// ----------------------------------------------------------------------------
package hbm_pkg;

	localparam int SeqBits   = 24;
	localparam int CntBits   = 32;
	localparam int TickBits  = 16;
	localparam int WordBits  = 32;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;

	localparam logic [7:0] PingType = 8'hA1;
	localparam logic [7:0] AckType  = 8'hA2;

	localparam logic [TickBits-1:0] StartupReset = 16'd200;
	localparam logic [TickBits-1:0] TimeoutReset = 16'd500;
	localparam logic [TickBits-1:0] PeriodReset  = 16'd1000;

	// item kinds
	localparam logic [1:0] FuncTick       = 2'd0;
	localparam logic [1:0] FuncMessage    = 2'd1;
	localparam logic [1:0] FuncSendResult = 2'd2;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegStartup = 2'd0;
	localparam logic [CfgIdxW-1:0] RegTimeout = 2'd1;
	localparam logic [CfgIdxW-1:0] RegPeriod  = 2'd2;

	typedef enum logic [1:0] {
		PhStartup = 2'd0,
		PhSending = 2'd1,
		PhWaiting = 2'd2,
		PhPeriod  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [TickBits-1:0] startup_ticks;
		logic [TickBits-1:0] ack_timeout_ticks;
		logic [TickBits-1:0] period_ticks;
	} hbm_cfg_t;

endpackage

// ===== hdl/hbm_cfg.sv =====
// ----------------------------------------------------------------------------
// hbm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module hbm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [hbm_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [hbm_pkg::CfgDataW-1:0]   cfg_data,
	output hbm_pkg::hbm_cfg_t              cfg
);
	import hbm_pkg::*;

	hbm_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_ticks     <= StartupReset;
			cfg_q.ack_timeout_ticks <= TimeoutReset;
			cfg_q.period_ticks      <= PeriodReset;
		end else if (cfg_write) begin
			unique case (cfg_index)
				RegStartup: cfg_q.startup_ticks     <= cfg_data;
				RegTimeout: cfg_q.ack_timeout_ticks <= cfg_data;
				RegPeriod:  cfg_q.period_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/hbm_core.sv =====
// ----------------------------------------------------------------------------
// hbm_core
// Heartbeat state machine, timer, pending notification and counters.
// Updates once per item; the state registers double as the result fields.
// ----------------------------------------------------------------------------
module hbm_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [1:0]                      func,
	input  logic [hbm_pkg::WordBits-1:0]    message,
	input  logic                            send_ok,
	input  hbm_pkg::hbm_cfg_t               cfg,
	output logic                            ping_request,
	output logic [hbm_pkg::WordBits-1:0]    ping_word,
	output logic                            ack_matched,
	output logic [hbm_pkg::CntBits-1:0]     sent_count,
	output logic [hbm_pkg::CntBits-1:0]     received_count,
	output logic [hbm_pkg::CntBits-1:0]     timeout_count,
	output logic [hbm_pkg::CntBits-1:0]     protocol_error_count,
	output logic [1:0]                      phase
);
	import hbm_pkg::*;

	phase_t                phase_q, phase_d;
	logic [SeqBits-1:0]    seq_q, seq_d, seq_inc;
	logic [TickBits-1:0]   timer_q, timer_d, limit;
	logic [TickBits:0]     tick_next;
	logic                  tick_hit;
	logic                  pend_valid_q, pend_valid_d;
	logic [WordBits-1:0]   pend_word_q, pend_word_d, reply_word;
	logic                  reply_hit, resolve;
	logic [CntBits-1:0]    sent_q, sent_d, recv_q, recv_d, tmo_q, tmo_d, err_q, err_d;
	logic                  request_q, request_d, matched_q, matched_d;

	always_comb begin
		unique case (phase_q)
			PhStartup: limit = cfg.startup_ticks;
			PhPeriod:  limit = cfg.period_ticks;
			default:   limit = cfg.ack_timeout_ticks;
		endcase
	end

	assign tick_next = {1'b0, timer_q} + (TickBits+1)'(1);
	assign tick_hit  = tick_next >= {1'b0, limit};

	// sequence wraps and skips zero
	assign seq_inc = (seq_q + SeqBits'(1) == '0) ? SeqBits'(1) : seq_q + SeqBits'(1);

	assign reply_word = (func == FuncMessage) ? message : pend_word_q;
	assign reply_hit  = (reply_word[31:24] == AckType) && (reply_word[23:0] == 24'(seq_q));

	// a reply wait resolves on a live message or on the held notification
	assign resolve = ((func == FuncMessage) && (phase_q == PhWaiting)) ||
		((func == FuncSendResult) && (phase_q == PhSending) && send_ok && pend_valid_q);

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (func)
			FuncTick: begin
				if (phase_q != PhSending && tick_hit)
					phase_d = (phase_q == PhWaiting) ? PhPeriod : PhSending;
			end
			FuncMessage: begin
				if (phase_q == PhWaiting)
					phase_d = PhPeriod;
			end
			FuncSendResult: begin
				if (phase_q == PhSending)
					phase_d = (send_ok && !pend_valid_q) ? PhWaiting : PhPeriod;
			end
			default: ;
		endcase
	end

	// datapath and result flags
	always_comb begin
		seq_d        = seq_q;
		timer_d      = timer_q;
		pend_valid_d = pend_valid_q;
		pend_word_d  = pend_word_q;
		sent_d       = sent_q;
		recv_d       = recv_q;
		tmo_d        = tmo_q;
		err_d        = err_q;
		request_d    = 1'b0;
		matched_d    = resolve && reply_hit;
		if (resolve && !reply_hit)
			err_d = err_q + CntBits'(1);
		unique case (func)
			FuncTick: begin
				if (phase_q != PhSending) begin
					timer_d = tick_hit ? '0 : tick_next[TickBits-1:0];
					if (tick_hit && phase_q == PhWaiting)
						tmo_d = tmo_q + CntBits'(1);
					if (tick_hit && phase_q != PhWaiting) begin
						seq_d     = seq_inc;
						request_d = 1'b1;
					end
				end
			end
			FuncMessage: begin
				recv_d = recv_q + CntBits'(1);
				if (phase_q == PhWaiting) begin
					timer_d = '0;
				end else begin
					pend_valid_d = 1'b1;
					pend_word_d  = message;
				end
			end
			FuncSendResult: begin
				if (phase_q == PhSending) begin
					timer_d = '0;
					if (send_ok) begin
						sent_d       = sent_q + CntBits'(1);
						pend_valid_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PhStartup;
			seq_q        <= '0;
			timer_q      <= '0;
			pend_valid_q <= 1'b0;
			pend_word_q  <= '0;
			sent_q       <= '0;
			recv_q       <= '0;
			tmo_q        <= '0;
			err_q        <= '0;
			request_q    <= 1'b0;
			matched_q    <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			seq_q        <= seq_d;
			timer_q      <= timer_d;
			pend_valid_q <= pend_valid_d;
			pend_word_q  <= pend_word_d;
			sent_q       <= sent_d;
			recv_q       <= recv_d;
			tmo_q        <= tmo_d;
			err_q        <= err_d;
			request_q    <= request_d;
			matched_q    <= matched_d;
		end
	end

	assign ping_request         = request_q;
	assign ping_word            = {PingType, (WordBits-8)'(seq_q)};
	assign ack_matched          = matched_q;
	assign sent_count           = sent_q;
	assign received_count       = recv_q;
	assign timeout_count        = tmo_q;
	assign protocol_error_count = err_q;
	assign phase                = phase_q;

endmodule

// ===== hdl/ping_ack_heartbeat_monitor.sv =====
// ----------------------------------------------------------------------------
// ping_ack_heartbeat_monitor
// Inter-core heartbeat monitor: pings the partner each period, checks replies
// and counts sends, receives, timeouts and protocol errors.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | func, message, send_ok
//  out      | out_valid / out_ready| ping_request, ping_word, ack_matched,
//           |                      | four counters, phase
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds. A result passes through
// the input register, then the state and result registers, to the output.
// The whole state update of an item is one pass through hbm_core.
// A stalled output holds the input register; a new item is still taken into
// it while the output waits, then in_ready drops.
// After reset the block is ready at once; config resets to 200/500/1000.
// ----------------------------------------------------------------------------
module ping_ack_heartbeat_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [hbm_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [hbm_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      func,
	input  logic [hbm_pkg::WordBits-1:0]    message,
	input  logic                            send_ok,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            ping_request,
	output logic [hbm_pkg::WordBits-1:0]    ping_word,
	output logic                            ack_matched,
	output logic [hbm_pkg::CntBits-1:0]     sent_count,
	output logic [hbm_pkg::CntBits-1:0]     received_count,
	output logic [hbm_pkg::CntBits-1:0]     timeout_count,
	output logic [hbm_pkg::CntBits-1:0]     protocol_error_count,
	output logic [1:0]                      phase
);
	import hbm_pkg::*;

	hbm_cfg_t             cfg;
	logic                 valid_s1_q, out_valid_q, advance;
	logic [1:0]           func_s1;
	logic [WordBits-1:0]  message_s1;
	logic                 send_ok_s1;

	// the held item moves into the state once the result slot is free
	assign advance  = valid_s1_q && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1_q <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			message_s1 <= message;
			send_ok_s1 <= send_ok;
		end
	end

	hbm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hbm_core u_core (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (advance),
		.func                 (func_s1),
		.message              (message_s1),
		.send_ok              (send_ok_s1),
		.cfg                  (cfg),
		.ping_request         (ping_request),
		.ping_word            (ping_word),
		.ack_matched          (ack_matched),
		.sent_count           (sent_count),
		.received_count       (received_count),
		.timeout_count        (timeout_count),
		.protocol_error_count (protocol_error_count),
		.phase                (phase)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/hbm_checker.sv =====
// ----------------------------------------------------------------------------
// hbm_checker
// Port-level checks of the heartbeat monitor, bound to the top level.
// ----------------------------------------------------------------------------
module hbm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            ping_request,
	input logic [hbm_pkg::WordBits-1:0]    ping_word,
	input logic                            ack_matched,
	input logic [hbm_pkg::CntBits-1:0]     sent_count,
	input logic [1:0]                      phase
);
	import hbm_pkg::*;

	// a stalled result keeps its fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sent_count) && $stable(ping_word))
		else $error("result changed while stalled");

	// a ping request always leaves the block waiting for the send result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ping_request |-> phase == PhSending && !ack_matched)
		else $error("ping request outside send phase");

	// a requested ping carries the ping type and a nonzero sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ping_request |-> ping_word[31:24] == PingType && ping_word[23:0] != 24'd0)
		else $error("bad ping word");

	// a match resolves the wait into the period phase
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_matched |-> phase == PhPeriod)
		else $error("match outside period phase");

endmodule

bind ping_ack_heartbeat_monitor hbm_checker u_hbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.ping_request (ping_request),
	.ping_word    (ping_word),
	.ack_matched  (ack_matched),
	.sent_count   (sent_count),
	.phase        (phase)
);
